// ===== rtl/cec_pkg.sv =====
// Shared widths, side-data type and saturation helper for the circle collision pipeline.
`default_nettype none
package cec_pkg;

  localparam int CoordW = 32;
  localparam int RadW   = 31;
  localparam int DiffW  = 33;
  localparam int MagW   = 33;
  localparam int ProdW  = 66;
  localparam int SumW   = 67;
  localparam int KW     = 68;
  localparam int KMagW  = 66;
  localparam int SqW    = 64;
  localparam int RsW    = 32;
  localparam int DenW   = 96;
  localparam int TW     = 98;
  localparam int ChunkW = 33;
  localparam int PpW    = 65;
  localparam int NumW   = 130;
  localparam int QuoW   = 41;
  localparam int CmpW   = DenW + QuoW;
  localparam int AccW   = QuoW + 2;
  localparam int FrontStages = 9;

  typedef struct packed {
    logic                     hit;
    logic                     neg_x;
    logic                     neg_y;
    logic signed [CoordW-1:0] vx1;
    logic signed [CoordW-1:0] vy1;
    logic signed [CoordW-1:0] vx2;
    logic signed [CoordW-1:0] vy2;
  } side_t;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(64'sd2147483647);
    lo = -AccW'(64'sd2147483648);
    if (v > hi) begin
      sat32 = {1'b0, {(CoordW-1){1'b1}}};
    end else if (v < lo) begin
      sat32 = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      sat32 = v[CoordW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cec_front.sv =====
// Front pipeline: differences, dot products, hit test, denominator and numerators.
`default_nettype none
module cec_front import cec_pkg::*; (
  input  wire                       clk,
  input  wire  [FrontStages-1:0]    en,
  input  wire  signed [CoordW-1:0]  first_x,
  input  wire  signed [CoordW-1:0]  first_y,
  input  wire  signed [CoordW-1:0]  first_vx,
  input  wire  signed [CoordW-1:0]  first_vy,
  input  wire  [RadW-1:0]           first_radius,
  input  wire  signed [CoordW-1:0]  second_x,
  input  wire  signed [CoordW-1:0]  second_y,
  input  wire  signed [CoordW-1:0]  second_vx,
  input  wire  signed [CoordW-1:0]  second_vy,
  input  wire  [RadW-1:0]           second_radius,
  output logic [3:0][NumW-1:0]      num,
  output logic [DenW-1:0]           den,
  output side_t                     side
);

  // stage 1
  logic signed [DiffW-1:0] dx1, dy1, dvx1, dvy1;
  logic [RsW-1:0]          rs1, r1x2_1, r2x2_1;
  side_t                   sd1;
  // stage 2
  logic [MagW-1:0]         mdx2, mdy2, mdvx2, mdvy2;
  logic                    px2, py2;
  logic [RsW-1:0]          rs2, r1x2_2, r2x2_2;
  side_t                   sd2;
  // stage 3
  logic [ProdW-1:0]        sxx3, syy3, kx3, ky3;
  logic [SqW-1:0]          lim3;
  logic [MagW-1:0]         mdx3, mdy3;
  logic                    px3, py3;
  logic [RsW-1:0]          rs3, r1x2_3, r2x2_3;
  side_t                   sd3;
  // stage 4
  logic [SumW-1:0]         s4;
  logic signed [KW-1:0]    k4;
  logic [SqW-1:0]          lim4;
  logic [MagW-1:0]         mdx4, mdy4;
  logic [RsW-1:0]          rs4, r1x2_4, r2x2_4;
  side_t                   sd4;
  // stage 5
  logic [SqW-1:0]          s5;
  logic [KMagW-1:0]        kmag5;
  logic [RsW-1:0]          dmx5, dmy5;
  logic [RsW-1:0]          rs5, r1x2_5, r2x2_5;
  side_t                   sd5;
  // stage 6
  logic [SqW-1:0]          dp0_6, dp1_6;
  logic [PpW-1:0]          a0_6, a1_6, b0_6, b1_6;
  logic [RsW-1:0]          dmx6, dmy6;
  side_t                   sd6;
  // stage 7
  logic [DenW-1:0]         den7;
  logic [TW-1:0]           t1_7, t2_7;
  logic [RsW-1:0]          dmx7, dmy7;
  side_t                   sd7;
  // stage 8
  logic [PpW-1:0]          pp8 [4][3];
  logic [DenW-1:0]         den8;
  side_t                   sd8;

  logic signed [KW-1:0]    kxs, kys;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx1    <= $signed({second_x[CoordW-1], second_x}) - $signed({first_x[CoordW-1], first_x});
      dy1    <= $signed({second_y[CoordW-1], second_y}) - $signed({first_y[CoordW-1], first_y});
      dvx1   <= $signed({second_vx[CoordW-1], second_vx})
                - $signed({first_vx[CoordW-1], first_vx});
      dvy1   <= $signed({second_vy[CoordW-1], second_vy})
                - $signed({first_vy[CoordW-1], first_vy});
      rs1    <= RsW'(first_radius) + RsW'(second_radius);
      r1x2_1 <= {first_radius, 1'b0};
      r2x2_1 <= {second_radius, 1'b0};
      sd1    <= '{hit: 1'b0, neg_x: 1'b0, neg_y: 1'b0,
                  vx1: first_vx, vy1: first_vy, vx2: second_vx, vy2: second_vy};
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mdx2   <= dx1[DiffW-1]  ? MagW'(-dx1)  : MagW'(dx1);
      mdy2   <= dy1[DiffW-1]  ? MagW'(-dy1)  : MagW'(dy1);
      mdvx2  <= dvx1[DiffW-1] ? MagW'(-dvx1) : MagW'(dvx1);
      mdvy2  <= dvy1[DiffW-1] ? MagW'(-dvy1) : MagW'(dvy1);
      px2    <= dvx1[DiffW-1] ^ dx1[DiffW-1];
      py2    <= dvy1[DiffW-1] ^ dy1[DiffW-1];
      rs2    <= rs1;
      r1x2_2 <= r1x2_1;
      r2x2_2 <= r2x2_1;
      sd2    <= '{hit: sd1.hit, neg_x: dx1[DiffW-1], neg_y: dy1[DiffW-1],
                  vx1: sd1.vx1, vy1: sd1.vy1, vx2: sd1.vx2, vy2: sd1.vy2};
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sxx3   <= mdx2 * mdx2;
      syy3   <= mdy2 * mdy2;
      kx3    <= mdvx2 * mdx2;
      ky3    <= mdvy2 * mdy2;
      lim3   <= rs2 * rs2;
      mdx3   <= mdx2;
      mdy3   <= mdy2;
      px3    <= px2;
      py3    <= py2;
      rs3    <= rs2;
      r1x2_3 <= r1x2_2;
      r2x2_3 <= r2x2_2;
      sd3    <= sd2;
    end
  end

  always_comb begin
    kxs = px3 ? -$signed({2'b00, kx3}) : $signed({2'b00, kx3});
    kys = py3 ? -$signed({2'b00, ky3}) : $signed({2'b00, ky3});
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4     <= SumW'(sxx3) + SumW'(syy3);
      k4     <= kxs + kys;
      lim4   <= lim3;
      mdx4   <= mdx3;
      mdy4   <= mdy3;
      rs4    <= rs3;
      r1x2_4 <= r1x2_3;
      r2x2_4 <= r2x2_3;
      sd4    <= sd3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5      <= s4[SqW-1:0];
      kmag5   <= KMagW'(-k4);
      dmx5    <= mdx4[RsW-1:0];
      dmy5    <= mdy4[RsW-1:0];
      rs5     <= rs4;
      r1x2_5  <= r1x2_4;
      r2x2_5  <= r2x2_4;
      sd5     <= '{hit: (s4 != '0) && (s4 <= SumW'(lim4)) && k4[KW-1],
                   neg_x: sd4.neg_x, neg_y: sd4.neg_y,
                   vx1: sd4.vx1, vy1: sd4.vy1, vx2: sd4.vx2, vy2: sd4.vy2};
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      dp0_6 <= s5[31:0] * rs5;
      dp1_6 <= s5[63:32] * rs5;
      a0_6  <= kmag5[ChunkW-1:0] * r2x2_5;
      a1_6  <= kmag5[KMagW-1:ChunkW] * r2x2_5;
      b0_6  <= kmag5[ChunkW-1:0] * r1x2_5;
      b1_6  <= kmag5[KMagW-1:ChunkW] * r1x2_5;
      dmx6  <= dmx5;
      dmy6  <= dmy5;
      sd6   <= sd5;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      den7 <= DenW'(dp0_6) + (DenW'(dp1_6) << 32);
      t2_7 <= TW'(a0_6) + (TW'(a1_6) << ChunkW);
      t1_7 <= TW'(b0_6) + (TW'(b1_6) << ChunkW);
      dmx7 <= dmx6;
      dmy7 <= dmy6;
      sd7  <= sd6;
    end
  end

  // products 0,1: second radius term on x,y; 2,3: first radius term on x,y
  always_ff @(posedge clk) begin
    if (en[7]) begin
      pp8[0][0] <= t2_7[32:0]  * dmx7;
      pp8[0][1] <= t2_7[65:33] * dmx7;
      pp8[0][2] <= PpW'(t2_7[97:66] * dmx7);
      pp8[1][0] <= t2_7[32:0]  * dmy7;
      pp8[1][1] <= t2_7[65:33] * dmy7;
      pp8[1][2] <= PpW'(t2_7[97:66] * dmy7);
      pp8[2][0] <= t1_7[32:0]  * dmx7;
      pp8[2][1] <= t1_7[65:33] * dmx7;
      pp8[2][2] <= PpW'(t1_7[97:66] * dmx7);
      pp8[3][0] <= t1_7[32:0]  * dmy7;
      pp8[3][1] <= t1_7[65:33] * dmy7;
      pp8[3][2] <= PpW'(t1_7[97:66] * dmy7);
      den8      <= den7;
      sd8       <= sd7;
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      for (int c = 0; c < 4; c++) begin
        num[c] <= NumW'(pp8[c][0]) + (NumW'(pp8[c][1]) << ChunkW)
                  + (NumW'(pp8[c][2]) << (2 * ChunkW));
      end
      den  <= den8;
      side <= sd8;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cec_div.sv =====
// Restoring divider pipeline: one quotient bit per stage for four numerators over one divisor.
`default_nettype none
module cec_div import cec_pkg::*; (
  input  wire                        clk,
  input  wire  [QuoW-1:0]            en,
  input  wire  [3:0][NumW-1:0]       num,
  input  wire  [DenW-1:0]            den,
  input  side_t                      side_in,
  output logic [3:0][QuoW-1:0]       quo,
  output side_t                      side_out
);

  logic [3:0][NumW-1:0] rem [QuoW+1];
  logic [3:0][QuoW-1:0] qb  [QuoW+1];
  logic [DenW-1:0]      dv  [QuoW+1];
  side_t                sd  [QuoW+1];

  assign rem[0] = num;
  assign qb[0]  = '0;
  assign dv[0]  = den;
  assign sd[0]  = side_in;

  for (genvar j = 0; j < QuoW; j++) begin : g_stage
    localparam int B = QuoW - 1 - j;
    logic [CmpW-1:0]      sh;
    logic [3:0][NumW-1:0] rem_next;
    logic [3:0][QuoW-1:0] qb_next;

    always_comb begin
      sh = CmpW'(dv[j]) << B;
      for (int c = 0; c < 4; c++) begin
        rem_next[c] = rem[j][c];
        qb_next[c]  = qb[j][c];
        if (sh <= CmpW'(rem[j][c])) begin
          rem_next[c] = rem[j][c] - sh[NumW-1:0];
          qb_next[c][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j+1] <= rem_next;
        qb[j+1]  <= qb_next;
        dv[j+1]  <= dv[j];
        sd[j+1]  <= sd[j];
      end
    end
  end

  assign quo      = qb[QuoW];
  assign side_out = sd[QuoW];

endmodule
`default_nettype wire

// ===== rtl/circle_elastic_collision.sv =====
// Top level of the elastic circle collision pipeline.
// Usage:
//   Input channel in_valid/in_ready carries two circles per item: centres,
//   velocities and radii in Q16.16. Output channel out_valid/out_ready carries
//   the new velocities and the collided flag, one result per item, in order.
//   Pipeline: 51 register stages (9 front, 41 divider and 1 output stage).
//   Throughput: one item per cycle unless stalled, set by the fully pipelined
//   divider with one quotient bit per stage and by the split front multipliers.
//   Each stage has its own valid bit and advances when empty or when the next
//   stage advances, so bubbles close up and input is taken while a result waits.
//   When the receiver stalls, the output holds and the pipeline fills behind it;
//   in_ready falls only when every stage holds an item.
//   Reset (rst, synchronous) clears all valid bits; no result is lost or
//   repeated across a stall.
`default_nettype none
module circle_elastic_collision import cec_pkg::*; (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire  signed [CoordW-1:0]  first_x,
  input  wire  signed [CoordW-1:0]  first_y,
  input  wire  signed [CoordW-1:0]  first_vx,
  input  wire  signed [CoordW-1:0]  first_vy,
  input  wire  [RadW-1:0]           first_radius,
  input  wire  signed [CoordW-1:0]  second_x,
  input  wire  signed [CoordW-1:0]  second_y,
  input  wire  signed [CoordW-1:0]  second_vx,
  input  wire  signed [CoordW-1:0]  second_vy,
  input  wire  [RadW-1:0]           second_radius,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic signed [CoordW-1:0]  new_first_vx,
  output logic signed [CoordW-1:0]  new_first_vy,
  output logic signed [CoordW-1:0]  new_second_vx,
  output logic signed [CoordW-1:0]  new_second_vy,
  output logic                      collided
);

  localparam int NS = FrontStages + QuoW + 1;

  logic [NS-1:0]         vld;
  logic [NS-1:0]         en;
  logic [3:0][NumW-1:0]  num;
  logic [DenW-1:0]       den;
  side_t                 side_f;
  side_t                 side_d;
  logic [3:0][QuoW-1:0]  quo;
  logic signed [AccW-1:0] acc [4];

  always_comb begin
    en[NS-1] = !vld[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  cec_front u_front (
    .clk           (clk),
    .en            (en[FrontStages-1:0]),
    .first_x       (first_x),
    .first_y       (first_y),
    .first_vx      (first_vx),
    .first_vy      (first_vy),
    .first_radius  (first_radius),
    .second_x      (second_x),
    .second_y      (second_y),
    .second_vx     (second_vx),
    .second_vy     (second_vy),
    .second_radius (second_radius),
    .num           (num),
    .den           (den),
    .side          (side_f)
  );

  cec_div u_div (
    .clk      (clk),
    .en       (en[FrontStages+QuoW-1:FrontStages]),
    .num      (num),
    .den      (den),
    .side_in  (side_f),
    .quo      (quo),
    .side_out (side_d)
  );

  always_comb begin
    acc[0] = AccW'(side_d.vx1) + (side_d.neg_x ? $signed({2'b00, quo[0]})
                                               : -$signed({2'b00, quo[0]}));
    acc[1] = AccW'(side_d.vy1) + (side_d.neg_y ? $signed({2'b00, quo[1]})
                                               : -$signed({2'b00, quo[1]}));
    acc[2] = AccW'(side_d.vx2) + (side_d.neg_x ? -$signed({2'b00, quo[2]})
                                               : $signed({2'b00, quo[2]}));
    acc[3] = AccW'(side_d.vy2) + (side_d.neg_y ? -$signed({2'b00, quo[3]})
                                               : $signed({2'b00, quo[3]}));
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      collided      <= side_d.hit;
      new_first_vx  <= side_d.hit ? sat32(acc[0]) : side_d.vx1;
      new_first_vy  <= side_d.hit ? sat32(acc[1]) : side_d.vy1;
      new_second_vx <= side_d.hit ? sat32(acc[2]) : side_d.vx2;
      new_second_vy <= side_d.hit ? sat32(acc[3]) : side_d.vy2;
    end
  end

`ifndef SYNTH
  a_ready_when_empty_out: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with output stage empty");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted item missing from first stage");

  a_stall_holds_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !in_ready |=> !in_ready || !out_valid || out_ready)
    else $error("pipeline opened while stalled and full");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the two-circle elastic collision pipeline.
`timescale 1ns / 1ps
module tb;
  import cec_pkg::*;

  typedef struct {
    logic signed [CoordW-1:0] x1, y1, vx1, vy1;
    logic [RadW-1:0] r1;
    logic signed [CoordW-1:0] x2, y2, vx2, vy2;
    logic [RadW-1:0] r2;
  } pair_t;

  typedef struct {
    logic signed [CoordW-1:0] vx1, vy1, vx2, vy2;
    logic hit;
  } bounce_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CoordW-1:0] first_x = '0, first_y = '0, first_vx = '0, first_vy = '0;
  logic signed [CoordW-1:0] second_x = '0, second_y = '0, second_vx = '0, second_vy = '0;
  logic [RadW-1:0] first_radius = '0, second_radius = '0;
  logic signed [CoordW-1:0] new_first_vx, new_first_vy, new_second_vx, new_second_vy;
  logic collided;

  pair_t pending_pairs[$];
  bounce_t bounce_q[$];
  int errors = 0;
  int taken = 0;
  int results = 0;
  int hits = 0;
  int quiet = 0;
  int in_idle = 0;
  int out_idle = 0;
  logic took_last = 1'b0;
  logic drained_once = 1'b0;

  circle_elastic_collision DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic signed [CoordW-1:0] clamp32(input logic signed [255:0] v);
    if (v > 256'sd2147483647) return 32'sh7fffffff;
    if (v < -256'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic bounce_t bounce_of(input pair_t p);
    logic signed [255:0] dx, dy, dvx, dvy, s, k, rs, den, kmag, adx, ady;
    logic signed [255:0] r1, r2, qx1, qy1, qx2, qy2;
    bounce_t b;
    dx = $signed(p.x2) - $signed(p.x1);
    dy = $signed(p.y2) - $signed(p.y1);
    dvx = $signed(p.vx2) - $signed(p.vx1);
    dvy = $signed(p.vy2) - $signed(p.vy1);
    r1 = {225'b0, p.r1};
    r2 = {225'b0, p.r2};
    rs = r1 + r2;
    s = dx * dx + dy * dy;
    k = dvx * dx + dvy * dy;
    b.hit = (s != 0) && (s <= rs * rs) && (k < 0);
    b.vx1 = p.vx1; b.vy1 = p.vy1; b.vx2 = p.vx2; b.vy2 = p.vy2;
    if (b.hit) begin
      den = rs * s;
      kmag = -k;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      qx1 = (kmag * 2 * r2 * adx) / den;
      qy1 = (kmag * 2 * r2 * ady) / den;
      qx2 = (kmag * 2 * r1 * adx) / den;
      qy2 = (kmag * 2 * r1 * ady) / den;
      b.vx1 = clamp32($signed(p.vx1) + (dx < 0 ? qx1 : -qx1));
      b.vy1 = clamp32($signed(p.vy1) + (dy < 0 ? qy1 : -qy1));
      b.vx2 = clamp32($signed(p.vx2) + (dx < 0 ? -qx2 : qx2));
      b.vy2 = clamp32($signed(p.vy2) + (dy < 0 ? -qy2 : qy2));
    end
    return b;
  endfunction

  task automatic add_pair(input int x1, y1, vx1, vy1, r1,
                          input int x2, y2, vx2, vy2, r2);
    pair_t p;
    p.x1 = x1; p.y1 = y1; p.vx1 = vx1; p.vy1 = vy1; p.r1 = RadW'(r1);
    p.x2 = x2; p.y2 = y2; p.vx2 = vx2; p.vy2 = vy2; p.r2 = RadW'(r2);
    pending_pairs.push_back(p);
  endtask

  function automatic int spread(input int lim);
    return $signed($urandom_range(2 * lim, 0)) - lim;
  endfunction

  task automatic report(input string what, input logic signed [31:0] got, exp_v);
    $display("mismatch on %s at result %0d: got %h expected %h", what, results, got, exp_v);
    errors++;
  endtask

  initial begin
    pair_t p;
    int unsigned rmax;
    int rsum;
    add_pair(0, 0, 65536, 0, 65536, 0, 0, -65536, 0, 65536);
    add_pair(5, 5, 100, 100, 0, 5, 5, -100, -100, 0);
    add_pair(0, 0, 0, 0, 0, 1, 0, -5, 0, 0);
    add_pair(0, 0, -65536, 0, 65536, 65536, 0, 65536, 0, 65536);
    add_pair(0, 0, 0, 65536, 65536, 65536, 0, 0, -65536, 65536);
    add_pair(0, 0, 65536, 0, 65536, 131072, 0, -65536, 0, 65536);
    add_pair(0, 0, 65536, 0, 65536, 131073, 0, -65536, 0, 65536);
    add_pair(0, 0, 32'h7fff0000, 0, 16, 65536, 0, 32'h80010000, 0, 1 << 30);
    add_pair(0, 0, 0, 32'h7fff0000, 1 << 30, 0, 65536, 0, 32'h80010000, 16);
    add_pair(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
             32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    add_pair(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
             32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_pair(-1, -1, -1, -1, 32'h7fffffff, -1, -1, -1, -1, 32'h7fffffff);
    add_pair(0, 0, 0, 0, 1, 1, 1, -1, -1, 1);
    add_pair(100, -200, 300, 400, 65536, 40000, 30000, -5000, -7000, 65536);
    add_pair(0, 0, 0, 0, 0, -3, 4, 1, -1, 5);
    add_pair(1000, 1000, 1, 2, 500, 1000, 1400, 3, -9, 0);
    for (int i = 0; i < 600; i++) begin
      if ($urandom_range(3, 0) == 0) begin
        p.x1 = $urandom; p.y1 = $urandom; p.vx1 = $urandom; p.vy1 = $urandom;
        p.x2 = $urandom; p.y2 = $urandom; p.vx2 = $urandom; p.vy2 = $urandom;
        p.r1 = RadW'($urandom); p.r2 = RadW'($urandom);
        if ($urandom_range(1, 0)) begin
          p.x2 = p.x1 + spread(int'(p.r1 >> 1));
          p.y2 = p.y1 + spread(int'(p.r2 >> 1));
        end
      end else begin
        case ($urandom_range(2, 0))
          0: rmax = 64;
          1: rmax = 1 << 20;
          default: rmax = 32'h3fffffff;
        endcase
        p.r1 = RadW'($urandom_range(rmax, 0));
        p.r2 = RadW'($urandom_range(rmax, 0));
        rsum = int'((p.r1 + p.r2) / 2);
        p.x1 = $urandom; p.y1 = $urandom;
        p.x2 = p.x1 + spread(rsum);
        p.y2 = p.y1 + spread(rsum);
        rmax = $urandom_range(1, 0) ? 1 << 18 : 32'h7fffffff;
        p.vx1 = spread(rmax); p.vy1 = spread(rmax);
        p.vx2 = spread(rmax); p.vy2 = spread(rmax);
      end
      pending_pairs.push_back(p);
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (pending_pairs.size() == 0 && !in_valid);
    wait (bounce_q.size() == 0);
    repeat (60) @(posedge clk);
    $display("%0d circle pairs driven, %0d results checked, %0d of them collisions",
             taken, results, hits);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    took_last <= in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      pair_t p;
      p.x1 = first_x; p.y1 = first_y; p.vx1 = first_vx; p.vy1 = first_vy;
      p.r1 = first_radius;
      p.x2 = second_x; p.y2 = second_y; p.vx2 = second_vx; p.vy2 = second_vy;
      p.r2 = second_radius;
      bounce_q.push_back(bounce_of(p));
      taken++;
    end
    if (!rst && out_valid && out_ready) begin
      if (bounce_q.size() == 0) begin
        $display("unexpected result %0d", results);
        errors++;
      end else begin
        bounce_t b;
        b = bounce_q.pop_front();
        if (new_first_vx !== b.vx1) report("new_first_vx", new_first_vx, b.vx1);
        if (new_first_vy !== b.vy1) report("new_first_vy", new_first_vy, b.vy1);
        if (new_second_vx !== b.vx2) report("new_second_vx", new_second_vx, b.vx2);
        if (new_second_vy !== b.vy2) report("new_second_vy", new_second_vy, b.vy2);
        if (collided !== b.hit) report("collided", collided, b.hit);
        hits += b.hit;
      end
      results++;
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 3000) begin
      $display("no progress for %0d cycles", quiet);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic calm();
    return taken >= 500 || ((taken / 100) % 3 == 2);
  endfunction

  always @(negedge clk) begin
    logic go;
    if (!rst && !(in_valid && !took_last)) begin
      go = pending_pairs.size() != 0;
      if (in_idle > 0) begin
        in_idle--;
        go = 1'b0;
      end else if (!calm() && $urandom_range(7, 0) == 0) begin
        in_idle = $urandom_range(16, 1) - 1;
        go = 1'b0;
      end
      if (taken == 300 && !drained_once) begin
        if (bounce_q.size() != 0) go = 1'b0;
        else drained_once = 1'b1;
      end
      if (go) begin
        pair_t p;
        p = pending_pairs.pop_front();
        first_x <= p.x1; first_y <= p.y1; first_vx <= p.vx1; first_vy <= p.vy1;
        first_radius <= p.r1;
        second_x <= p.x2; second_y <= p.y2; second_vx <= p.vx2; second_vy <= p.vy2;
        second_radius <= p.r2;
      end
      in_valid <= go;
    end
    if (!rst) begin
      if (out_idle > 0) begin
        out_idle--;
        out_ready <= 1'b0;
      end else if (!calm() && $urandom_range(7, 0) == 0) begin
        out_idle = $urandom_range(16, 1) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

endmodule

// ===== sim.f =====
rtl/cec_pkg.sv
rtl/cec_front.sv
rtl/cec_div.sv
rtl/circle_elastic_collision.sv
tb/sv/tb.sv
